// ===== rtl/ges_pkg.sv =====
package ges_pkg;

	// fixed sheet geometry
	localparam int MAX_CELL_SIZE = 64;
	localparam int GRID_CELLS    = 16;
	localparam int GRID_W        = $clog2(GRID_CELLS);
	localparam int SIZE_W        = 7;
	localparam int COORD_W       = $clog2(MAX_CELL_SIZE);
	localparam int IDX_W         = 8;
	localparam int POS_W         = 10;
	localparam int COLOR_W       = 32;
	localparam int ADV_W         = 6;

	localparam logic [SIZE_W-1:0] SIZE_RESET = SIZE_W'(8);
	localparam logic [SIZE_W-1:0] SIZE_MAX   = SIZE_W'(MAX_CELL_SIZE);
	localparam logic [SIZE_W-1:0] NONE_FOUND = {SIZE_W{1'b1}};
	localparam logic [IDX_W-1:0]  REF_GLYPH  = IDX_W'(65);
	localparam logic [IDX_W-1:0]  LAST_CELL  = IDX_W'(GRID_CELLS * GRID_CELLS - 1);

	// pixel queue between front and back
	localparam int QDEPTH = 4;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	typedef enum logic [0:0] {
		REG_CELL_WIDTH  = 1'b0,
		REG_CELL_HEIGHT = 1'b1
	} reg_idx_t;

	typedef struct packed {
		logic [SIZE_W-1:0] width;
		logic [SIZE_W-1:0] height;
	} cfg_t;

	// one classified pixel
	typedef struct packed {
		logic               sheet_start;
		logic               ink;
		logic               cell_end;
		logic [COORD_W-1:0] col;
		logic [COORD_W-1:0] row;
		logic [IDX_W-1:0]   cell_idx;
	} pix_t;

	typedef struct packed {
		logic [ADV_W-1:0]  space_advance;
		logic [SIZE_W-1:0] line_advance;
		logic [SIZE_W-1:0] trimmed_height;
		logic [SIZE_W-1:0] top_trim;
		logic              sheet_done;
		logic [POS_W-1:0]  cell_top_y;
		logic [SIZE_W-1:0] glyph_width;
		logic [POS_W-1:0]  glyph_left;
		logic [IDX_W-1:0]  glyph_code;
	} result_t;

endpackage

// ===== rtl/glyph_extent_scanner.sv =====
// Glyph extent scanner: one result word per glyph cell out, and one pixel word per cycle in
// while the pixel queue is not full. A cell's last pixel goes through the queue to the tracker,
// which loads the result register. The 4-deep queue sits between the classifier and
// the extent tracker, and the result register lets the tracker keep going while a result waits.
// Reset (arst_n low, asynchronous): cell size 8x8, background 0, counters at cell 0,
// queue and result register empty.
module glyph_extent_scanner (
	input  logic                       clk,
	input  logic                       arst_n,
	// pixel stream
	input  logic                       s_axis_tvalid,
	output logic                       s_axis_tready,
	input  logic [31:0]                s_axis_tdata,  // pixel_color
	input  logic                       s_axis_tuser,  // sheet_start
	// result stream
	output logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	// glyph_code[7:0] glyph_left[17:8] glyph_width[24:18] cell_top_y[34:25]
	// top_trim[41:35] trimmed_height[48:42] line_advance[55:49] space_advance[61:56], pad
	output logic [63:0]                m_axis_tdata,
	output logic                       m_axis_tlast,  // sheet_done
	// register write port
	input  logic                       cfg_we,
	input  logic [0:0]                 cfg_index,
	input  logic [ges_pkg::SIZE_W-1:0] cfg_wdata
);

	ges_pkg::cfg_t             cfg_q;
	logic [ges_pkg::SIZE_W-1:0] size_clamped;

	logic            q_full, q_nonempty, push, pop;
	ges_pkg::pix_t   wr_entry, head;
	ges_pkg::result_t res;

	// out-of-range sizes: zero reads as one, anything past the maximum as the maximum
	always_comb begin
		if (cfg_wdata == '0)
			size_clamped = ges_pkg::SIZE_W'(1);
		else if (cfg_wdata > ges_pkg::SIZE_MAX)
			size_clamped = ges_pkg::SIZE_MAX;
		else
			size_clamped = cfg_wdata;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.width  <= ges_pkg::SIZE_RESET;
			cfg_q.height <= ges_pkg::SIZE_RESET;
		end else if (cfg_we) begin
			unique case (cfg_index)
				ges_pkg::REG_CELL_WIDTH:  cfg_q.width  <= size_clamped;
				ges_pkg::REG_CELL_HEIGHT: cfg_q.height <= size_clamped;
				default: ;
			endcase
		end
	end

	// front: background capture, pixel/row/cell counting, ink test
	ges_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg_q),
		.in_valid (s_axis_tvalid),
		.in_color (s_axis_tdata),
		.in_start (s_axis_tuser),
		.q_full   (q_full),
		.in_ready (s_axis_tready),
		.push     (push),
		.entry    (wr_entry)
	);

	ges_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.wr_entry (wr_entry),
		.pop      (pop),
		.full     (q_full),
		.nonempty (q_nonempty),
		.head     (head)
	);

	// back: running extents, sheet metrics and the result register
	ges_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg        (cfg_q),
		.q_nonempty (q_nonempty),
		.head       (head),
		.pop        (pop),
		.res_valid  (m_axis_tvalid),
		.res_ready  (m_axis_tready),
		.res        (res)
	);

	assign m_axis_tlast = res.sheet_done;
	assign m_axis_tdata = {2'b00, res.space_advance, res.line_advance, res.trimmed_height,
		res.top_trim, res.cell_top_y, res.glyph_width, res.glyph_left, res.glyph_code};

endmodule

// ===== rtl/ges_front.sv =====
module ges_front (
	input  logic                           clk,
	input  logic                           arst_n,
	input  ges_pkg::cfg_t                  cfg,
	input  logic                           in_valid,
	input  logic [ges_pkg::COLOR_W-1:0]    in_color,
	input  logic                           in_start,
	input  logic                           q_full,
	output logic                           in_ready,
	output logic                           push,
	output ges_pkg::pix_t                  entry
);

	logic [ges_pkg::COLOR_W-1:0] bg_q;
	logic [ges_pkg::COORD_W-1:0] col_q, row_q;
	logic [ges_pkg::IDX_W-1:0]   idx_q;

	logic [ges_pkg::COLOR_W-1:0] bg_e;
	logic [ges_pkg::COORD_W-1:0] col_e, row_e;
	logic [ges_pkg::IDX_W-1:0]   idx_e;
	logic                        row_end, cell_end;

	assign in_ready = !q_full;
	assign push     = in_valid && !q_full;

	always_comb begin
		bg_e  = in_start ? in_color : bg_q;
		col_e = in_start ? '0 : col_q;
		row_e = in_start ? '0 : row_q;
		idx_e = in_start ? '0 : idx_q;
		row_end  = ({1'b0, col_e} + 1'b1) >= cfg.width;
		cell_end = row_end && (({1'b0, row_e} + 1'b1) >= cfg.height);

		entry.sheet_start = in_start;
		entry.ink         = in_color != bg_e;
		entry.cell_end    = cell_end;
		entry.col         = col_e;
		entry.row         = row_e;
		entry.cell_idx    = idx_e;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bg_q  <= '0;
			col_q <= '0;
			row_q <= '0;
			idx_q <= '0;
		end else if (push) begin
			bg_q <= bg_e;
			if (!row_end) begin
				col_q <= col_e + 1'b1;
				row_q <= row_e;
				idx_q <= idx_e;
			end else if (!cell_end) begin
				col_q <= '0;
				row_q <= row_e + 1'b1;
				idx_q <= idx_e;
			end else begin
				col_q <= '0;
				row_q <= '0;
				idx_q <= idx_e + 1'b1; // wraps to cell 0 after the last cell
			end
		end
	end

endmodule

// ===== rtl/ges_queue.sv =====
module ges_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  ges_pkg::pix_t wr_entry,
	input  logic          pop,
	output logic          full,
	output logic          nonempty,
	output ges_pkg::pix_t head
);

	ges_pkg::pix_t               slot_q [ges_pkg::QDEPTH];
	logic [ges_pkg::QPTR_W-1:0]  wr_ptr_q, rd_ptr_q;
	logic [ges_pkg::QCNT_W-1:0]  cnt_q;

	assign full     = cnt_q == ges_pkg::QCNT_W'(ges_pkg::QDEPTH);
	assign nonempty = cnt_q != '0;
	assign head     = slot_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push)
			slot_q[wr_ptr_q] <= wr_entry;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
		end else begin
			if (push)
				wr_ptr_q <= wr_ptr_q + 1'b1;
			if (pop)
				rd_ptr_q <= rd_ptr_q + 1'b1;
			if (push && !pop)
				cnt_q <= cnt_q + 1'b1;
			else if (pop && !push)
				cnt_q <= cnt_q - 1'b1;
		end
	end

	a_cnt_bound: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q <= ges_pkg::QCNT_W'(ges_pkg::QDEPTH))
		else $error("queue count beyond depth");
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> nonempty)
		else $error("pop from empty queue");

endmodule

// ===== rtl/ges_back.sv =====
module ges_back (
	input  logic            clk,
	input  logic            arst_n,
	input  ges_pkg::cfg_t   cfg,
	input  logic            q_nonempty,
	input  ges_pkg::pix_t   head,
	output logic            pop,
	output logic            res_valid,
	input  logic            res_ready,
	output ges_pkg::result_t res
);

	logic [ges_pkg::SIZE_W-1:0] lm_q, rm_q, stm_q, rb_q;
	logic [ges_pkg::SIZE_W-1:0] lm_e, rm_e, stm_e, rb_e;
	logic [ges_pkg::SIZE_W-1:0] lm_n, rm_n, stm_n, rb_n;
	logic [ges_pkg::SIZE_W-1:0] col_x, row_x;
	logic                       out_valid_q;
	ges_pkg::result_t           out_q, res_d;
	logic                       emit, done, found;
	logic [ges_pkg::GRID_W-1:0] ccol, crow;
	logic [ges_pkg::POS_W-1:0]  origin_x;
	logic [ges_pkg::SIZE_W:0]   span_hi;

	assign pop       = q_nonempty && !(head.cell_end && out_valid_q && !res_ready);
	assign emit      = pop && head.cell_end;
	assign res_valid = out_valid_q;
	assign res       = out_q;

	always_comb begin
		col_x = {1'b0, head.col};
		row_x = {1'b0, head.row};
		lm_e  = head.sheet_start ? cfg.width  : lm_q;
		rm_e  = head.sheet_start ? ges_pkg::NONE_FOUND : rm_q;
		stm_e = head.sheet_start ? cfg.height : stm_q;
		rb_e  = head.sheet_start ? cfg.height : rb_q;

		lm_n  = (head.ink && col_x < lm_e) ? col_x : lm_e;
		rm_n  = (head.ink && (rm_e == ges_pkg::NONE_FOUND || col_x > rm_e)) ? col_x : rm_e;
		stm_n = (head.ink && row_x < stm_e) ? row_x : stm_e;
		rb_n  = (head.ink && head.cell_idx == ges_pkg::REF_GLYPH) ? row_x : rb_e;

		done  = head.cell_idx == ges_pkg::LAST_CELL;
		found = rm_n != ges_pkg::NONE_FOUND;
		ccol  = head.cell_idx[ges_pkg::GRID_W-1:0];
		crow  = head.cell_idx[2*ges_pkg::GRID_W-1:ges_pkg::GRID_W];
		origin_x = ges_pkg::POS_W'(ges_pkg::POS_W'(ccol) * ges_pkg::POS_W'(cfg.width));
		span_hi  = {1'b0, rm_n} + 1'b1;

		res_d.glyph_code  = head.cell_idx;
		res_d.glyph_left  = found ? origin_x + ges_pkg::POS_W'(lm_n) : origin_x;
		if (!found)
			res_d.glyph_width = cfg.width;
		else if (span_hi > {1'b0, lm_n})
			res_d.glyph_width = ges_pkg::SIZE_W'(span_hi - {1'b0, lm_n});
		else
			res_d.glyph_width = '0;
		res_d.cell_top_y  =
			ges_pkg::POS_W'(ges_pkg::POS_W'(crow) * ges_pkg::POS_W'(cfg.height));
		res_d.sheet_done  = done;
		res_d.top_trim       = done ? stm_n : '0;
		res_d.trimmed_height = (done && cfg.height > stm_n) ? cfg.height - stm_n : '0;
		res_d.line_advance   = (done && rb_n > stm_n) ? rb_n - stm_n : '0;
		res_d.space_advance  = done ? cfg.width[ges_pkg::SIZE_W-1:1] : '0;
	end

	always_ff @(posedge clk) begin
		if (emit)
			out_q <= res_d;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			lm_q        <= ges_pkg::SIZE_RESET;
			rm_q        <= ges_pkg::NONE_FOUND;
			stm_q       <= ges_pkg::SIZE_RESET;
			rb_q        <= ges_pkg::SIZE_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (emit)
				out_valid_q <= 1'b1;
			else if (res_ready)
				out_valid_q <= 1'b0;
			if (pop) begin
				if (head.cell_end) begin
					lm_q  <= cfg.width;
					rm_q  <= ges_pkg::NONE_FOUND;
					stm_q <= done ? cfg.height : stm_n;
					rb_q  <= done ? cfg.height : rb_n;
				end else begin
					lm_q  <= lm_n;
					rm_q  <= rm_n;
					stm_q <= stm_n;
					rb_q  <= rb_n;
				end
			end
		end
	end

	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.sheet_done |-> out_q.glyph_code == ges_pkg::LAST_CELL)
		else $error("sheet end flagged on a cell other than the last");
	a_width_range: assert property (@(posedge clk) disable iff (!arst_n)
		emit && !found |-> res_d.glyph_width != '0)
		else $error("empty cell with zero width");
	a_stall_holds: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !res_ready |=> out_valid_q)
		else $error("result dropped while stalled");

endmodule

// ===== verif/ges_extent_checker.sv =====
`timescale 1ns / 1ps
module ges_extent_checker (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       s_axis_tvalid,
	input  logic                       s_axis_tready,
	input  logic [31:0]                s_axis_tdata,
	input  logic                       s_axis_tuser,
	input  logic                       m_axis_tvalid,
	input  logic                       m_axis_tready,
	input  logic [63:0]                m_axis_tdata,
	input  logic                       m_axis_tlast,
	input  logic                       cfg_we,
	input  logic [0:0]                 cfg_index,
	input  logic [ges_pkg::SIZE_W-1:0] cfg_wdata,
	output int                         mismatches,
	output int                         pending
);

	// mirrored cell size and scan state
	logic [ges_pkg::SIZE_W-1:0]  cell_w, cell_h;
	logic [ges_pkg::COLOR_W-1:0] backdrop;
	logic [ges_pkg::COORD_W-1:0] col, row;
	logic [ges_pkg::IDX_W-1:0]   cell_no;
	logic [ges_pkg::SIZE_W-1:0]  ink_left, ink_right, sheet_top, a_bottom;

	ges_pkg::result_t due_glyphs[$];
	int               words_seen;

	function automatic logic [ges_pkg::SIZE_W-1:0] clamp_size(
			input logic [ges_pkg::SIZE_W-1:0] v);
		if (v == '0)
			return ges_pkg::SIZE_W'(1);
		if (v > ges_pkg::SIZE_MAX)
			return ges_pkg::SIZE_MAX;
		return v;
	endfunction

	function automatic logic [ges_pkg::SIZE_W-1:0] floor_sub(
			input logic [ges_pkg::SIZE_W-1:0] a, input logic [ges_pkg::SIZE_W-1:0] b);
		return (a > b) ? a - b : '0;
	endfunction

	task automatic open_cell();
		col = '0;
		row = '0;
		ink_left = cell_w;
		ink_right = ges_pkg::NONE_FOUND;
	endtask

	task automatic open_sheet();
		cell_no = '0;
		sheet_top = cell_h;
		a_bottom = cell_h;
		open_cell();
	endtask

	task automatic flag_mismatch(input string msg);
		$display("%0t ges_extent_checker: %s", $time, msg);
		mismatches++;
	endtask

	task automatic field_check(input string name, input int unsigned got,
			input int unsigned want);
		if (got != want)
			flag_mismatch($sformatf("word %0d %s: got %0d, expected %0d",
				words_seen, name, got, want));
	endtask

	// one pixel through the extent scan; a closing pixel queues its glyph
	task automatic scan_pixel(input logic [ges_pkg::COLOR_W-1:0] color, input logic start);
		ges_pkg::result_t           r;
		logic [ges_pkg::SIZE_W-1:0] col_w, row_w;
		logic [ges_pkg::POS_W-1:0]  origin;
		if (start) begin
			backdrop = color;
			open_sheet();
		end
		col_w = ges_pkg::SIZE_W'(col);
		row_w = ges_pkg::SIZE_W'(row);
		if (color != backdrop) begin
			if (col_w < ink_left)
				ink_left = col_w;
			if (ink_right == ges_pkg::NONE_FOUND || col_w > ink_right)
				ink_right = col_w;
			if (row_w < sheet_top)
				sheet_top = row_w;
			if (cell_no == ges_pkg::REF_GLYPH)
				a_bottom = row_w;
		end
		// row and cell close once the counter reaches the size or beyond
		if (int'(col_w) + 1 < int'(cell_w)) begin
			col++;
			return;
		end
		if (int'(row_w) + 1 < int'(cell_h)) begin
			col = '0;
			row++;
			return;
		end
		r = '0;
		origin = ges_pkg::POS_W'(int'(cell_no[ges_pkg::GRID_W-1:0]) * int'(cell_w));
		r.glyph_code = cell_no;
		if (ink_right != ges_pkg::NONE_FOUND) begin
			r.glyph_left = ges_pkg::POS_W'(int'(origin) + int'(ink_left));
			r.glyph_width = floor_sub(ink_right + ges_pkg::SIZE_W'(1), ink_left);
		end else begin
			r.glyph_left = origin;
			r.glyph_width = cell_w;
		end
		r.cell_top_y = ges_pkg::POS_W'(
			int'(cell_no[ges_pkg::IDX_W-1:ges_pkg::GRID_W]) * int'(cell_h));
		r.sheet_done = (cell_no == ges_pkg::LAST_CELL);
		if (r.sheet_done) begin
			r.top_trim = sheet_top;
			r.trimmed_height = floor_sub(cell_h, sheet_top);
			r.line_advance = floor_sub(a_bottom, sheet_top);
			r.space_advance = ges_pkg::ADV_W'(cell_w >> 1);
			open_sheet();
		end else begin
			cell_no++;
			open_cell();
		end
		due_glyphs.push_back(r);
	endtask

	task automatic check_glyph();
		ges_pkg::result_t got, want;
		got = '0;
		got.glyph_code     = m_axis_tdata[7:0];
		got.glyph_left     = m_axis_tdata[17:8];
		got.glyph_width    = m_axis_tdata[24:18];
		got.cell_top_y     = m_axis_tdata[34:25];
		got.top_trim       = m_axis_tdata[41:35];
		got.trimmed_height = m_axis_tdata[48:42];
		got.line_advance   = m_axis_tdata[55:49];
		got.space_advance  = m_axis_tdata[61:56];
		got.sheet_done     = m_axis_tlast;
		if (due_glyphs.size() == 0) begin
			flag_mismatch($sformatf("word %0d with nothing due, glyph_code %0d",
				words_seen, got.glyph_code));
		end else begin
			want = due_glyphs.pop_front();
			field_check("glyph_code", got.glyph_code, want.glyph_code);
			field_check("glyph_left", got.glyph_left, want.glyph_left);
			field_check("glyph_width", got.glyph_width, want.glyph_width);
			field_check("cell_top_y", got.cell_top_y, want.cell_top_y);
			field_check("sheet_done", got.sheet_done, want.sheet_done);
			field_check("top_trim", got.top_trim, want.top_trim);
			field_check("trimmed_height", got.trimmed_height, want.trimmed_height);
			field_check("line_advance", got.line_advance, want.line_advance);
			field_check("space_advance", got.space_advance, want.space_advance);
		end
		words_seen++;
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cell_w = ges_pkg::SIZE_RESET;
			cell_h = ges_pkg::SIZE_RESET;
			backdrop = '0;
			open_sheet();
			due_glyphs.delete();
			mismatches = 0;
			pending = 0;
			words_seen = 0;
		end else begin
			// result side first, so a stray word is never matched to this edge's pixel
			if (m_axis_tvalid && m_axis_tready)
				check_glyph();
			if (s_axis_tvalid && s_axis_tready)
				scan_pixel(s_axis_tdata, s_axis_tuser);
			if (cfg_we) begin
				case (ges_pkg::reg_idx_t'(cfg_index))
				ges_pkg::REG_CELL_WIDTH: begin
					cell_w = clamp_size(cfg_wdata);
				end
				ges_pkg::REG_CELL_HEIGHT: begin
					cell_h = clamp_size(cfg_wdata);
				end
				default: begin
				end
				endcase
			end
			pending = due_glyphs.size();
		end
	end

endmodule

// ===== verif/tb_glyph_extent_scanner.sv =====
`timescale 1ns / 1ps
module tb_glyph_extent_scanner;

	localparam int RANDOM_PIXELS = 2000;
	// no word moving on either side for this long means the block is hung
	localparam int IDLE_LIMIT    = 2000;
	// covers the 4-deep pixel queue and the result register, with margin
	localparam int SETTLE_CYCLES = 16;

	typedef enum int {
		SINK_OPEN,
		SINK_COIN,
		SINK_PERIODIC
	} sink_mode_t;

	logic                        clk = 1'b0;
	logic                        arst_n = 1'b0;
	logic                        s_axis_tvalid = 1'b0;
	logic                        s_axis_tready;
	logic [31:0]                 s_axis_tdata = '0;
	logic                        s_axis_tuser = 1'b0;
	logic                        m_axis_tvalid;
	logic                        m_axis_tready = 1'b0;
	logic [63:0]                 m_axis_tdata;
	logic                        m_axis_tlast;
	logic                        cfg_we = 1'b0;
	logic [0:0]                  cfg_index = '0;
	logic [ges_pkg::SIZE_W-1:0]  cfg_wdata = '0;

	int mismatch_count;
	int glyphs_due;

	// sender pacing and what the stimulus knows of the sheet
	int                          burst_left = 0;
	int                          gap_max = 0;
	int                          pixels_sent = 0;
	int                          cur_w = 8;
	int                          cur_h = 8;
	logic [ges_pkg::COLOR_W-1:0] backdrop_tx = '0;

	always #1 clk = ~clk;

	glyph_extent_scanner u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata)
	);

	ges_extent_checker u_check (
		.clk           (clk),
		.arst_n        (arst_n),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tuser  (s_axis_tuser),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.cfg_we        (cfg_we),
		.cfg_index     (cfg_index),
		.cfg_wdata     (cfg_wdata),
		.mismatches    (mismatch_count),
		.pending       (glyphs_due)
	);

	// Pixel word out. Entered just after a falling edge; returns just after the
	// falling edge that follows acceptance, so tvalid is only ever set once per step.
	task automatic send_pixel(input logic [ges_pkg::COLOR_W-1:0] color, input logic start);
		int gap;
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 40);
			gap = (gap_max == 0) ? 0 : $urandom_range(0, gap_max);
			if (gap != 0) begin
				s_axis_tvalid <= 1'b0;
				repeat (gap) @(negedge clk);
			end
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= color;
		s_axis_tuser  <= start;
		if (start)
			backdrop_tx = color;
		do
			@(posedge clk);
		while (!s_axis_tready);
		@(negedge clk);
		burst_left--;
		pixels_sent++;
	endtask

	// Drain: every due glyph back, then give the pixel queue time to empty, since
	// mid-cell pixels leave nothing to wait for.
	task automatic quiesce();
		s_axis_tvalid <= 1'b0;
		while (glyphs_due != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(negedge clk);
	endtask

	// Both registers, raw values; 0 and anything above 64 get clamped by the block.
	task automatic set_cell_size(input logic [ges_pkg::SIZE_W-1:0] w,
			input logic [ges_pkg::SIZE_W-1:0] h);
		cfg_we    <= 1'b1;
		cfg_index <= ges_pkg::REG_CELL_WIDTH;
		cfg_wdata <= w;
		@(negedge clk);
		cfg_index <= ges_pkg::REG_CELL_HEIGHT;
		cfg_wdata <= h;
		@(negedge clk);
		cfg_we <= 1'b0;
		cur_w = (w == '0) ? 1 : ((w > ges_pkg::SIZE_MAX) ? ges_pkg::MAX_CELL_SIZE : int'(w));
		cur_h = (h == '0) ? 1 : ((h > ges_pkg::SIZE_MAX) ? ges_pkg::MAX_CELL_SIZE : int'(h));
	endtask

	// Whole cells at the current size. With restart the first pixel opens a new
	// sheet; stray_pm is the per-mille chance of a sheet start landing mid-run.
	task automatic send_cells(input int cells, input bit restart, input int stray_pm);
		int                          area, dens, p;
		bit                          blank, start;
		logic [ges_pkg::COLOR_W-1:0] color;
		area = cur_w * cur_h;
		blank = ($urandom_range(0, 9) == 0);
		dens = 0;
		for (p = 0; p < cells * area; p++) begin
			// ink density per cell: empty cells, sparse, dense and near solid
			if (p % area == 0 && !blank) begin
				case ($urandom_range(0, 3))
				0: dens = 0;
				1: dens = 4;
				2: dens = 30;
				default: dens = 85;
				endcase
			end
			start = (p == 0 && restart) || ($urandom_range(0, 999) < stray_pm);
			if (start) begin
				case ($urandom_range(0, 2))
				0: color = '0;
				1: color = '1;
				default: color = $urandom;
				endcase
			end else if ($urandom_range(0, 99) < dens) begin
				// half the ink differs from the background in a single bit
				if ($urandom_range(0, 1))
					color = backdrop_tx ^ (32'h1 << $urandom_range(0, 31));
				else
					color = $urandom;
			end else begin
				color = backdrop_tx;
			end
			send_pixel(color, start);
		end
	endtask

	// Result side: each stretch picks its own pattern. The periodic one raises
	// tready only once per period, so the result register and queue back up.
	initial begin : result_sink
		sink_mode_t mode;
		int         stretch, period, tick;
		forever begin
			mode = sink_mode_t'($urandom_range(0, 2));
			stretch = $urandom_range(64, 256);
			period = $urandom_range(2, 12);
			for (tick = 0; tick < stretch; tick++) begin
				@(negedge clk);
				case (mode)
				SINK_OPEN: m_axis_tready <= 1'b1;
				SINK_COIN: m_axis_tready <= 1'($urandom_range(0, 1));
				default: m_axis_tready <= (tick % period == period - 1);
				endcase
			end
		end
	end

	initial begin : watchdog
		int quiet;
		quiet = 0;
		while (quiet < IDLE_LIMIT) begin
			@(posedge clk);
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) || cfg_we)
				quiet = 0;
			else
				quiet++;
		end
		$display("*** FAILED ***");
		$finish;
	end

	initial begin : stimulus
		int                         kind, random_from;
		bit                         first;
		logic [ges_pkg::SIZE_W-1:0] raw_w, raw_h;

		repeat (3) @(negedge clk);
		arst_n <= 1'b1;

		// --- directed ---
		// at the reset size of 8x8, before any sheet start: background is zero
		send_pixel(32'h0000_0000, 1'b0);
		send_pixel(32'hFFFF_FFFF, 1'b0);
		send_pixel(32'h0000_0000, 1'b0);
		// shrink to 1x1 part-way through cell 0: the next pixel closes it
		quiesce();
		set_cell_size(7'd1, 7'd1);
		send_pixel(32'h1234_5678, 1'b0);
		// all-ones background; ink differing in top bit, bottom bit, everything
		send_pixel(32'hFFFF_FFFF, 1'b1);
		send_pixel(32'h7FFF_FFFF, 1'b0);
		send_pixel(32'hFFFF_FFFE, 1'b0);
		send_pixel(32'h0000_0000, 1'b0);
		send_pixel(32'hFFFF_FFFF, 1'b0);
		// sheet start on a zero background straight after another sheet start
		send_pixel(32'h0000_0000, 1'b1);
		send_pixel(32'h0000_0000, 1'b1);
		send_pixel(32'h8000_0001, 1'b0);
		// width written as 0 (taken as 1), height as 127 (taken as 64)
		quiesce();
		set_cell_size(7'd0, 7'h7F);
		send_pixel(32'h5A5A_A5A5, 1'b1);
		send_pixel(32'h5A5A_A5A5, 1'b0);
		send_pixel(32'hA5A5_5A5A, 1'b0);
		send_pixel(32'h5A5A_A5A5, 1'b0);
		// left mid-cell: the first random phase shrinks the height under it

		// --- random phases ---
		random_from = pixels_sent;
		first = 1'b1;
		while (pixels_sent - random_from < RANDOM_PIXELS) begin
			quiesce();
			case ($urandom_range(0, 2))
			0: gap_max = 0;
			1: gap_max = 3;
			default: gap_max = 12;
			endcase
			kind = first ? 0 : $urandom_range(0, 19);
			first = 1'b0;
			if (kind < 12) begin
				// full sheet of tiny cells, at most two pixels per cell
				raw_w = ges_pkg::SIZE_W'($urandom_range(0, 2));
				raw_h = (raw_w == 7'd2) ? ges_pkg::SIZE_W'($urandom_range(0, 1))
					: ges_pkg::SIZE_W'($urandom_range(0, 2));
				set_cell_size(raw_w, raw_h);
				send_cells(256, 1'b1, ($urandom_range(0, 4) == 0) ? 3 : 0);
			end else if (kind < 15) begin
				// a few mid-size cells, carrying on the old sheet half the time
				set_cell_size(ges_pkg::SIZE_W'($urandom_range(1, 6)),
					ges_pkg::SIZE_W'($urandom_range(1, 6)));
				send_cells($urandom_range(1, 24), 1'($urandom_range(0, 1)), 0);
			end else if (kind < 17) begin
				// widest cells along the top row and into the second
				raw_w = $urandom_range(0, 1) ? ges_pkg::SIZE_W'(64)
					: ges_pkg::SIZE_W'($urandom_range(65, 127));
				set_cell_size(raw_w, 7'd1);
				send_cells($urandom_range(16, 18), 1'b1, 0);
			end else if (kind < 18) begin
				// tallest cells
				raw_h = $urandom_range(0, 1) ? ges_pkg::SIZE_W'(64)
					: ges_pkg::SIZE_W'($urandom_range(65, 127));
				set_cell_size(7'd1, raw_h);
				send_cells($urandom_range(2, 4), 1'($urandom_range(0, 1)), 0);
			end else if (kind < 19) begin
				// run past the last cell with no new sheet start: scan wraps to cell 0
				set_cell_size(7'd1, 7'd1);
				send_cells(256 + $urandom_range(1, 40), 1'b1, 0);
			end else begin
				// noise: random colours, random sheet starts, any position in a cell
				set_cell_size(ges_pkg::SIZE_W'($urandom_range(0, 7)),
					ges_pkg::SIZE_W'($urandom_range(0, 7)));
				repeat ($urandom_range(20, 80))
					send_pixel($urandom, ($urandom_range(0, 7) == 0));
			end
		end

		// --- drain and verdict ---
		quiesce();
		if (mismatch_count == 0 && glyphs_due == 0)
			$display("*** PASSED ***");
		else
			$display("*** FAILED ***");
		$finish;
	end

endmodule
